/* src/qrs_pkg.sv */
// ----------------------------------------------------------------------------
// qrs_pkg: shared types and constants of the quadratic root solver
// Widths of the datapath and the outcome codes of a result item.
// ----------------------------------------------------------------------------
package qrs_pkg;

    localparam int COEF_W  = 16;   // Q8.8 coefficient
    localparam int ROOT_W  = 32;   // Q16.16 root
    localparam int RAD_W   = 64;   // discriminant scaled by 2^30
    localparam int SQRT_W  = 32;   // integer square root of the radicand
    localparam int DIVN_W  = 34;   // rounded numerator magnitude
    localparam int DIVD_W  = 16;   // divisor magnitude
    localparam int SIDE_W  = 1;    // default sideband width of the sub pipelines

    typedef enum logic [2:0] {
        OUT_ALL_X   = 3'd0,
        OUT_NO_ROOT = 3'd1,
        OUT_LINEAR  = 3'd2,
        OUT_DOUBLE  = 3'd3,
        OUT_TWO     = 3'd4
    } outcome_t;

endpackage

/* src/qrs_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// qrs_sqrt_pipe: pipelined integer square root
// One result bit per stage, floor(sqrt(rad)); sideband rides along.
// ----------------------------------------------------------------------------
module qrs_sqrt_pipe #(
    parameter int SW = qrs_pkg::SIDE_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [qrs_pkg::RAD_W-1:0]    in_rad,
    input  logic [SW-1:0]                in_side,
    output logic                         out_valid,
    output logic [qrs_pkg::SQRT_W-1:0]   out_root,
    output logic [SW-1:0]                out_side
);

    localparam int N  = qrs_pkg::SQRT_W;
    localparam int RW = qrs_pkg::SQRT_W + 4;

    logic                        v_reg    [0:N-1];
    logic [RW-1:0]               rem_reg  [0:N-1];
    logic [N-1:0]                root_reg [0:N-1];
    logic [qrs_pkg::RAD_W-1:0]   rad_reg  [0:N-1];
    logic [SW-1:0]               side_reg [0:N-1];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic                      v_in;
        logic [RW-1:0]             rem_in;
        logic [N-1:0]              root_in;
        logic [qrs_pkg::RAD_W-1:0] rad_in;
        logic [SW-1:0]             side_in;
        logic [RW:0]               diff;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = in_rad;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign root_in = root_reg[i-1];
            assign rad_in  = rad_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // trial subtract of (4*root + 1) from the shifted remainder
        assign diff = {1'b0, rem_in[RW-3:0], rad_in[qrs_pkg::RAD_W-1 -: 2]}
                    - {1'b0, 2'b00, root_in, 2'b01};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (adv) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[i] <= side_in;
                rad_reg[i]  <= {rad_in[qrs_pkg::RAD_W-3:0], 2'b00};
                if (!diff[RW]) begin
                    rem_reg[i]  <= diff[RW-1:0];
                    root_reg[i] <= {root_in[N-2:0], 1'b1};
                end else begin
                    rem_reg[i]  <= {rem_in[RW-3:0], rad_in[qrs_pkg::RAD_W-1 -: 2]};
                    root_reg[i] <= {root_in[N-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_root  = root_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* src/qrs_div_pipe.sv */
// ----------------------------------------------------------------------------
// qrs_div_pipe: pipelined unsigned restoring divider
// One quotient bit per stage; the divisor and sideband travel with the item.
// ----------------------------------------------------------------------------
module qrs_div_pipe #(
    parameter int SW = qrs_pkg::SIDE_W
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  logic                         in_valid,
    input  logic [qrs_pkg::DIVN_W-1:0]   in_num,
    input  logic [qrs_pkg::DIVD_W-1:0]   in_den,
    input  logic [SW-1:0]                in_side,
    output logic                         out_valid,
    output logic [qrs_pkg::DIVN_W-1:0]   out_quo,
    output logic [SW-1:0]                out_side
);

    localparam int N  = qrs_pkg::DIVN_W;
    localparam int DW = qrs_pkg::DIVD_W;

    logic          v_reg    [0:N-1];
    logic [DW-1:0] rem_reg  [0:N-1];
    logic [N-1:0]  w_reg    [0:N-1];
    logic [DW-1:0] den_reg  [0:N-1];
    logic [SW-1:0] side_reg [0:N-1];

    for (genvar i = 0; i < N; i++) begin : g_stage
        logic          v_in;
        logic [DW-1:0] rem_in;
        logic [N-1:0]  w_in;
        logic [DW-1:0] den_in;
        logic [SW-1:0] side_in;
        logic [DW:0]   x;
        logic [DW:0]   sub;
        logic          ge;

        if (i == 0) begin : g_first
            assign v_in    = in_valid;
            assign rem_in  = '0;
            assign w_in    = in_num;
            assign den_in  = in_den;
            assign side_in = in_side;
        end else begin : g_next
            assign v_in    = v_reg[i-1];
            assign rem_in  = rem_reg[i-1];
            assign w_in    = w_reg[i-1];
            assign den_in  = den_reg[i-1];
            assign side_in = side_reg[i-1];
        end

        // shift in the next dividend bit and try the subtract
        assign x   = {rem_in, w_in[N-1]};
        assign ge  = (x >= {1'b0, den_in});
        assign sub = x - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[i] <= 1'b0;
            end else if (adv) begin
                v_reg[i] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[i] <= side_in;
                den_reg[i]  <= den_in;
                w_reg[i]    <= {w_in[N-2:0], ge};
                rem_reg[i]  <= ge ? sub[DW-1:0] : x[DW-1:0];
            end
        end
    end

    assign out_valid = v_reg[N-1];
    assign out_quo   = w_reg[N-1];
    assign out_side  = side_reg[N-1];

endmodule

/* src/quadratic_root_solver_unit.sv */
// ----------------------------------------------------------------------------
// quadratic_root_solver_unit: real roots of a*x^2 + b*x + c = 0
// Exact fixed-point solver with pipelined square root and dividers.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item is a coefficient set a, b, c in signed Q8.8.
//   Result channel m_*: one item per input, carrying the outcome code, the
//   plus-branch and minus-branch roots in signed Q16.16 and a flag that is
//   set when a root was clamped to the Q16.16 range.
//   The item passes 71 register stages: input register, multiply,
//   discriminant, 32 square-root stages, numerator setup, 34 divider stages
//   and the output register. Throughput is one item per cycle unless
//   m_tready holds the pipeline; the pipeline is a chain of stages with
//   valid bits, and the whole chain advances when the output register is
//   empty or being taken.
//   While m_tready is low with a result waiting, the pipeline holds in place
//   and s_tready drops; nothing is lost or repeated.
//   Reset (aresetn low, synchronous) empties all stages; no item is pending
//   afterwards.
// ----------------------------------------------------------------------------
module quadratic_root_solver_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // coef_a[15:0], coef_b[31:16], coef_c[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata    // outcome[2:0], root_first[34:3],
                                   // root_second[66:35], saturated[67], zero pad
);

    localparam int CW = qrs_pkg::COEF_W;
    localparam int NW = qrs_pkg::DIVN_W;
    localparam int DW = qrs_pkg::DIVD_W;
    localparam int RW = qrs_pkg::ROOT_W;
    // sideband into the square root: a, b, c, disc negative, disc zero
    localparam int SQ_SIDE_W  = 3 * CW + 2;
    // sideband into divider one: outcome, first sign, first used, second used
    localparam int DV_SIDE_W  = 3 + 3;

    logic adv;

    // global advance: output register empty or taken
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;

    // stage 0: input register
    logic                 v0_reg;
    logic signed [CW-1:0] a0_reg, b0_reg, c0_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
        end else if (adv) begin
            v0_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a0_reg <= s_tdata[CW-1:0];
            b0_reg <= s_tdata[2*CW-1:CW];
            c0_reg <= s_tdata[3*CW-1:2*CW];
        end
    end

    // stage 1: products b*b and a*c
    logic                   v1_reg;
    logic signed [CW-1:0]   a1_reg, b1_reg, c1_reg;
    logic signed [2*CW-1:0] bb1_reg, ac1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= v0_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a1_reg  <= a0_reg;
            b1_reg  <= b0_reg;
            c1_reg  <= c0_reg;
            bb1_reg <= b0_reg * b0_reg;
            ac1_reg <= a0_reg * c0_reg;
        end
    end

    // stage 2: discriminant and radicand
    logic signed [2*CW+1:0] disc_next;
    logic                   v2_reg;
    logic signed [CW-1:0]   a2_reg, b2_reg, c2_reg;
    logic                   dneg2_reg, dzero2_reg;
    logic [qrs_pkg::RAD_W-1:0] rad2_reg;

    assign disc_next = {{2{bb1_reg[2*CW-1]}}, bb1_reg}
                     - {ac1_reg, 2'b00};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a2_reg     <= a1_reg;
            b2_reg     <= b1_reg;
            c2_reg     <= c1_reg;
            dneg2_reg  <= disc_next[2*CW+1];
            dzero2_reg <= (disc_next == '0);
            rad2_reg   <= disc_next[2*CW+1] ? '0
                        : {disc_next[qrs_pkg::RAD_W-31:0], 30'd0};
        end
    end

    // square root pipeline
    logic                        sq_valid;
    logic [qrs_pkg::SQRT_W-1:0]  sq_root;
    logic [SQ_SIDE_W-1:0]        sq_side;

    qrs_sqrt_pipe #(
        .SW(SQ_SIDE_W)
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v2_reg),
        .in_rad    (rad2_reg),
        .in_side   ({dzero2_reg, dneg2_reg, c2_reg, b2_reg, a2_reg}),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // stage 3: classify and set up the numerators and divisor
    logic signed [CW-1:0] a3, b3, c3;
    logic                 dneg3, dzero3;
    logic signed [NW:0]   base3, sext3, np3, nm3, nlin3;
    logic signed [NW:0]   n1_sel, n2_sel;
    logic signed [CW-1:0] den_sel;
    logic [NW:0]          mag1, mag2;
    logic [CW:0]          dmag;
    qrs_pkg::outcome_t    oc_sel;
    logic                 use1_sel, use2_sel;

    assign a3     = sq_side[CW-1:0];
    assign b3     = sq_side[2*CW-1:CW];
    assign c3     = sq_side[3*CW-1:2*CW];
    assign dneg3  = sq_side[3*CW];
    assign dzero3 = sq_side[3*CW+1];

    assign base3 = -({{(NW+1-CW){b3[CW-1]}}, b3} <<< 15);
    assign sext3 = {{(NW+1-qrs_pkg::SQRT_W){1'b0}}, sq_root};
    assign np3   = base3 + sext3;
    assign nm3   = base3 - sext3;
    assign nlin3 = -({{(NW+1-CW){c3[CW-1]}}, c3} <<< 16);

    always_comb begin
        oc_sel   = qrs_pkg::OUT_NO_ROOT;
        n1_sel   = np3;
        n2_sel   = nm3;
        den_sel  = a3;
        use1_sel = 1'b0;
        use2_sel = 1'b0;
        if (a3 == '0) begin
            den_sel = b3;
            n1_sel  = nlin3;
            if (b3 == '0) begin
                oc_sel = (c3 == '0) ? qrs_pkg::OUT_ALL_X : qrs_pkg::OUT_NO_ROOT;
            end else begin
                oc_sel   = qrs_pkg::OUT_LINEAR;
                use1_sel = 1'b1;
            end
        end else if (!dneg3) begin
            oc_sel   = dzero3 ? qrs_pkg::OUT_DOUBLE : qrs_pkg::OUT_TWO;
            use1_sel = 1'b1;
            use2_sel = 1'b1;
        end
    end

    assign mag1 = n1_sel[NW] ? -n1_sel : n1_sel;
    assign mag2 = n2_sel[NW] ? -n2_sel : n2_sel;
    assign dmag = den_sel[CW-1] ? -{den_sel[CW-1], den_sel} : {den_sel[CW-1], den_sel};

    logic              v3_reg;
    logic [NW-1:0]     u1_reg, u2_reg;
    logic [DW-1:0]     ud_reg;
    logic              neg1_reg, neg2_reg, use1_reg, use2_reg;
    qrs_pkg::outcome_t oc3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= sq_valid;
        end
    end

    // add half the divisor for round-to-nearest, ties away from zero
    always_ff @(posedge aclk) begin
        if (adv) begin
            u1_reg   <= mag1[NW-1:0] + NW'(dmag[CW-1:1]);
            u2_reg   <= mag2[NW-1:0] + NW'(dmag[CW-1:1]);
            ud_reg   <= dmag[DW-1:0];
            neg1_reg <= n1_sel[NW] ^ den_sel[CW-1];
            neg2_reg <= n2_sel[NW] ^ den_sel[CW-1];
            use1_reg <= use1_sel;
            use2_reg <= use2_sel;
            oc3_reg  <= oc_sel;
        end
    end

    // two dividers in lockstep
    logic                 dv1_valid, dv2_valid;
    logic [NW-1:0]        q1, q2;
    logic [DV_SIDE_W-1:0] dv1_side;
    logic                 dv2_side;

    qrs_div_pipe #(
        .SW(DV_SIDE_W)
    ) u_div_first (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v3_reg),
        .in_num    (u1_reg),
        .in_den    (ud_reg),
        .in_side   ({use2_reg, use1_reg, neg1_reg, oc3_reg}),
        .out_valid (dv1_valid),
        .out_quo   (q1),
        .out_side  (dv1_side)
    );

    qrs_div_pipe #(
        .SW(1)
    ) u_div_second (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (v3_reg),
        .in_num    (u2_reg),
        .in_den    (ud_reg),
        .in_side   (neg2_reg),
        .out_valid (dv2_valid),
        .out_quo   (q2),
        .out_side  (dv2_side)
    );

    // sign and saturate the quotients
    logic          neg1_o, use1_o, use2_o;
    logic [2:0]    oc_o;
    logic          sat1, sat2;
    logic [RW-1:0] r1, r2;

    assign oc_o   = dv1_side[2:0];
    assign neg1_o = dv1_side[3];
    assign use1_o = dv1_side[4];
    assign use2_o = dv1_side[5];

    always_comb begin
        sat1 = 1'b0;
        sat2 = 1'b0;
        if (neg1_o) begin
            sat1 = (q1 > NW'(64'h8000_0000));
            r1   = sat1 ? 32'h8000_0000 : -q1[RW-1:0];
        end else begin
            sat1 = (q1 > NW'(64'h7FFF_FFFF));
            r1   = sat1 ? 32'h7FFF_FFFF : q1[RW-1:0];
        end
        if (dv2_side) begin
            sat2 = (q2 > NW'(64'h8000_0000));
            r2   = sat2 ? 32'h8000_0000 : -q2[RW-1:0];
        end else begin
            sat2 = (q2 > NW'(64'h7FFF_FFFF));
            r2   = sat2 ? 32'h7FFF_FFFF : q2[RW-1:0];
        end
    end

    // output register
    logic          out_v_reg;
    logic [2:0]    out_oc_reg;
    logic [RW-1:0] out_r1_reg, out_r2_reg;
    logic          out_sat_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= dv1_valid & dv2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_oc_reg  <= oc_o;
            out_r1_reg  <= use1_o ? r1 : '0;
            out_r2_reg  <= use2_o ? r2 : '0;
            out_sat_reg <= (use1_o & sat1) | (use2_o & sat2);
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = {4'd0, out_sat_reg, out_r2_reg, out_r1_reg, out_oc_reg};

endmodule
